// ===== hdl/fmb_pkg.sv =====
package fmb_pkg;

   localparam int DIM       = 8;
   localparam int FRAC_BITS = 16;
   localparam int MAT_N     = DIM * DIM;
   localparam int ERI_N     = MAT_N * MAT_N;
   localparam int MAT_AW    = (MAT_N > 1) ? $clog2(MAT_N) : 1;
   localparam int ERI_AW    = (ERI_N > 1) ? $clog2(ERI_N) : 1;

   // cube root of a 32-bit value scaled by 2^(2*FRAC_BITS), three bits a step
   localparam int ROOT_NW = 32 + 2 * FRAC_BITS;
   localparam int ROOT_G  = (ROOT_NW + 2) / 3;
   localparam int ROOT_YW = ROOT_G;
   localparam int ROOT_RW = 2 * ROOT_G + 6;
   localparam int ROOT_CW = $clog2(ROOT_G + 1);

   // width of n * cbrt(n) after rounding off the fraction
   localparam int M_W = 32 + ROOT_YW + 1 - FRAC_BITS;

   localparam logic [31:0] THREE_OVER_PI_Q32 = 32'd4101391657;
   localparam logic [23:0] CX_Q24            = 24'(32'd3172085749 >> 8);

   typedef enum logic [2:0] {
      KIND_DENSITY  = 3'd0,
      KIND_OVERLAP  = 3'd1,
      KIND_KINETIC  = 3'd2,
      KIND_NUCLEAR  = 3'd3,
      KIND_INTEGRAL = 3'd4,
      KIND_START    = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      MODE_J = 2'd0,
      MODE_N = 2'd1,
      MODE_F = 2'd2
   } mode_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [11:0]        address;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         row;
      logic [2:0]         col;
      logic signed [31:0] fock_value;
      logic signed [31:0] xc_energy;
      logic               saturated;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic              clear;
      logic              issue;
      mode_type          mode;
      logic              grp_end;
      logic [MAT_AW-1:0] mat_addr;
      logic [ERI_AW-1:0] eri_addr;
      logic [MAT_AW-1:0] wr_idx;
      logic              x_load;
      logic              root_start;
      logic              root_sel_n;
      logic              v_load;
      logic              m_load;
      logic              e_load;
      logic              out_load;
      logic [2:0]        row;
      logic [2:0]        col;
      logic              last;
   } cmd_type;

   typedef struct packed {
      logic n_done;
      logic f_done;
      logic root_busy;
   } status_type;

   function automatic logic ovf32(input logic signed [63:0] v);
      return v[63:31] != {33{v[63]}};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (ovf32(v)) begin
         return v[63] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end
      return v[31:0];
   endfunction

endpackage

// ===== hdl/fmb_ram.sv =====
module fmb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/fmb_cbrt.sv =====
module fmb_cbrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [31:0]                 operand,
   output logic                        busy,
   output logic [fmb_pkg::ROOT_YW-1:0] root
);
   import fmb_pkg::*;

   logic                    busy_ff, busy_in;
   logic [ROOT_CW-1:0]      cnt_ff, cnt_in;
   logic [3*ROOT_G-1:0]     num_ff, num_in;
   logic [ROOT_RW-1:0]      rem_ff, rem_in;
   logic [ROOT_YW-1:0]      y_ff, y_in;
   logic [2*ROOT_YW-1:0]    y2_ff, y2_in;

   logic [ROOT_RW-1:0]      rem_sh, trial, t;
   logic [ROOT_YW-1:0]      y_d;
   logic [2*ROOT_YW-1:0]    y2_d;

   always_comb begin
      rem_sh = {rem_ff[ROOT_RW-4:0], num_ff[3*ROOT_G-1 -: 3]};
      y_d    = {y_ff[ROOT_YW-2:0], 1'b0};
      y2_d   = {y2_ff[2*ROOT_YW-3:0], 2'b00};
      // (2y+1)^3 - (2y)^3 = 3*(4y^2 + 2y) + 1
      t      = ROOT_RW'(y2_d) + ROOT_RW'(y_d);
      trial  = (t << 1) + t + ROOT_RW'(1);

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      y_in    = y_ff;
      y2_in   = y2_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = ROOT_CW'(ROOT_G);
         num_in  = (3*ROOT_G)'(operand) << (2 * FRAC_BITS);
         rem_in  = '0;
         y_in    = '0;
         y2_in   = '0;
      end else if (busy_ff) begin
         busy_in = cnt_ff != ROOT_CW'(1);
         cnt_in  = cnt_ff - ROOT_CW'(1);
         num_in  = num_ff << 3;
         if (rem_sh >= trial) begin
            rem_in = rem_sh - trial;
            y_in   = y_d | ROOT_YW'(1);
            y2_in  = y2_d + (2*ROOT_YW)'({y_d, 1'b0}) + (2*ROOT_YW)'(1);
         end else begin
            rem_in = rem_sh;
            y_in   = y_d;
            y2_in  = y2_d;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      y_ff   <= y_in;
      y2_ff  <= y2_in;
   end

   assign busy = busy_ff;
   assign root = y_ff;

endmodule

// ===== hdl/fmb_datapath.sv =====
module fmb_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_accept,
   input  fmb_pkg::req_type    req_data,
   input  fmb_pkg::cmd_type    cmd,
   output fmb_pkg::status_type st,
   output fmb_pkg::rsp_type    rsp_data
);
   import fmb_pkg::*;

   logic              mat_ok, eri_ok;
   logic              we_d, we_s, we_t, we_v, we_e;
   logic [MAT_AW-1:0] ld_mat_addr;
   logic [ERI_AW-1:0] ld_eri_addr;
   logic [31:0]       d_q, s_q, t_q, v_q, e_q, j_q;
   logic              jw_en;
   logic [MAT_AW-1:0] jw_addr;
   logic signed [31:0] jw_data;

   logic              a_valid_ff, b_valid_ff;
   mode_type          a_mode_ff, b_mode_ff;
   logic              a_end_ff, b_end_ff;
   logic [MAT_AW-1:0] a_idx_ff, b_idx_ff;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [33:0] tvj_ff, tvj_in;
   logic signed [31:0] opa, opb;

   logic signed [63:0] acc_ff, acc_in, sh, sum, fsum;
   logic signed [31:0] n_ff, n_in, n_sat;
   logic [31:0]        x_ff;
   logic [63:0]        xp;
   logic signed [31:0] v_ff;
   logic [M_W-1:0]     m_ff;
   logic [63:0]        mp, ep;
   logic [39:0]        e_w;
   logic signed [31:0] energy_ff, energy_in;
   logic               sat_ff, sat_in;
   logic               n_hit, f_hit, j_hit, e_ovf;
   rsp_type            rsp_ff;
   logic               root_busy;
   logic [ROOT_YW-1:0] root;

   // word loads
   always_comb begin
      mat_ok      = req_data.address < 12'(MAT_N);
      eri_ok      = {1'b0, req_data.address} < 13'(ERI_N);
      we_d        = req_accept && req_data.kind == KIND_DENSITY && mat_ok;
      we_s        = req_accept && req_data.kind == KIND_OVERLAP && mat_ok;
      we_t        = req_accept && req_data.kind == KIND_KINETIC && mat_ok;
      we_v        = req_accept && req_data.kind == KIND_NUCLEAR && mat_ok;
      we_e        = req_accept && req_data.kind == KIND_INTEGRAL && eri_ok;
      ld_mat_addr = req_data.address[MAT_AW-1:0];
      ld_eri_addr = req_data.address[ERI_AW-1:0];
   end

   fmb_ram #(.WIDTH(32), .DEPTH(MAT_N)) u_d_ram (
      .clock, .wr_en(we_d), .wr_addr(ld_mat_addr), .wr_data(req_data.value),
      .rd_addr(cmd.mat_addr), .rd_data(d_q));
   fmb_ram #(.WIDTH(32), .DEPTH(MAT_N)) u_s_ram (
      .clock, .wr_en(we_s), .wr_addr(ld_mat_addr), .wr_data(req_data.value),
      .rd_addr(cmd.mat_addr), .rd_data(s_q));
   fmb_ram #(.WIDTH(32), .DEPTH(MAT_N)) u_t_ram (
      .clock, .wr_en(we_t), .wr_addr(ld_mat_addr), .wr_data(req_data.value),
      .rd_addr(cmd.mat_addr), .rd_data(t_q));
   fmb_ram #(.WIDTH(32), .DEPTH(MAT_N)) u_v_ram (
      .clock, .wr_en(we_v), .wr_addr(ld_mat_addr), .wr_data(req_data.value),
      .rd_addr(cmd.mat_addr), .rd_data(v_q));
   fmb_ram #(.WIDTH(32), .DEPTH(ERI_N)) u_e_ram (
      .clock, .wr_en(we_e), .wr_addr(ld_eri_addr), .wr_data(req_data.value),
      .rd_addr(cmd.eri_addr), .rd_data(e_q));
   // holds J, then F overwrites it element by element
   fmb_ram #(.WIDTH(32), .DEPTH(MAT_N)) u_j_ram (
      .clock, .wr_en(jw_en), .wr_addr(jw_addr), .wr_data(jw_data),
      .rd_addr(cmd.mat_addr), .rd_data(j_q));

   fmb_cbrt u_cbrt (
      .clock, .reset, .start(cmd.root_start),
      .operand(cmd.root_sel_n ? n_ff : x_ff),
      .busy(root_busy), .root);

   // multiply stage
   always_comb begin
      opa     = (a_mode_ff == MODE_F) ? v_ff : $signed(d_q);
      opb     = (a_mode_ff == MODE_J) ? $signed(e_q) : $signed(s_q);
      prod_in = 64'(opa) * 64'(opb);
      tvj_in  = 34'($signed(t_q)) + 34'($signed(v_q)) + 34'($signed(j_q));
   end

   // accumulate and write-back stage
   always_comb begin
      sh    = prod_ff >>> FRAC_BITS;
      sum   = acc_ff + sh;
      fsum  = 64'(tvj_ff) + sh;
      j_hit = b_valid_ff && b_mode_ff == MODE_J && b_end_ff;
      f_hit = b_valid_ff && b_mode_ff == MODE_F;
      n_hit = b_valid_ff && b_mode_ff == MODE_N && b_end_ff;

      jw_en   = j_hit || f_hit;
      jw_addr = b_idx_ff;
      jw_data = sat32(f_hit ? fsum : sum);

      acc_in = acc_ff;
      if (cmd.clear) begin
         acc_in = '0;
      end else if (b_valid_ff && b_mode_ff != MODE_F) begin
         acc_in = b_end_ff ? 64'sd0 : sum;
      end

      n_sat = sat32(sum);
      n_in  = n_ff;
      if (n_hit) begin
         n_in = (n_sat < 32'sd1) ? 32'sd1 : n_sat;
      end

      xp = 64'(n_ff) * 64'(THREE_OVER_PI_Q32) + 64'h8000_0000;
      mp = 64'(n_ff) * 64'(root) + (64'd1 << (FRAC_BITS - 1));
      ep = 64'(m_ff) * 64'(CX_Q24) + (64'd1 << 23);
      e_w   = ep[63:24];
      e_ovf = e_w > 40'h00_8000_0000;

      energy_in = energy_ff;
      if (cmd.e_load) begin
         energy_in = e_ovf ? 32'sh80000000 : -$signed(e_w[31:0]);
      end

      sat_in = sat_ff;
      if (cmd.clear) begin
         sat_in = 1'b0;
      end else if ((jw_en && ovf32(f_hit ? fsum : sum)) || (n_hit && ovf32(sum))
                   || (cmd.e_load && e_ovf)) begin
         sat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         sat_ff     <= 1'b0;
      end else begin
         a_valid_ff <= cmd.issue;
         b_valid_ff <= a_valid_ff;
         sat_ff     <= sat_in;
      end
      a_mode_ff <= cmd.mode;
      a_end_ff  <= cmd.grp_end;
      a_idx_ff  <= cmd.wr_idx;
      b_mode_ff <= a_mode_ff;
      b_end_ff  <= a_end_ff;
      b_idx_ff  <= a_idx_ff;
      prod_ff   <= prod_in;
      tvj_ff    <= tvj_in;
      acc_ff    <= acc_in;
      n_ff      <= n_in;
      energy_ff <= energy_in;
      if (cmd.x_load) begin
         x_ff <= xp[63:32];
      end
      if (cmd.v_load) begin
         v_ff <= -$signed(32'(root));
      end
      if (cmd.m_load) begin
         m_ff <= M_W'(mp >> FRAC_BITS);
      end
      if (cmd.out_load) begin
         rsp_ff.row        <= cmd.row;
         rsp_ff.col        <= cmd.col;
         rsp_ff.fock_value <= $signed(j_q);
         rsp_ff.xc_energy  <= energy_ff;
         rsp_ff.saturated  <= sat_ff;
         rsp_ff.last       <= cmd.last;
      end
   end

   assign st.n_done    = n_hit;
   assign st.f_done    = f_hit && b_end_ff;
   assign st.root_busy = root_busy;
   assign rsp_data     = rsp_ff;

endmodule

// ===== hdl/fmb_ctrl.sv =====
module fmb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_accept,
   input  fmb_pkg::req_type    req_data,
   input  logic                rsp_stall,
   input  fmb_pkg::status_type st,
   output fmb_pkg::cmd_type    cmd,
   output logic                req_stall,
   output logic                rsp_valid
);
   import fmb_pkg::*;

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_JACC  = 16'h0002,
      S_NACC  = 16'h0004,
      S_WAITN = 16'h0008,
      S_XMUL  = 16'h0010,
      S_RXS   = 16'h0020,
      S_RXW   = 16'h0040,
      S_RNS   = 16'h0080,
      S_RNW   = 16'h0100,
      S_MMUL  = 16'h0200,
      S_EMUL  = 16'h0400,
      S_FACC  = 16'h0800,
      S_FWAIT = 16'h1000,
      S_ERD   = 16'h2000,
      S_ELD   = 16'h4000,
      S_EWAIT = 16'h8000
   } state_type;

   state_type         state_ff, state_in;
   logic [MAT_AW-1:0] mat_ff, mat_in, j_ff, j_in;
   logic [ERI_AW-1:0] eri_ff, eri_in;
   logic [2:0]        row_ff, row_in, col_ff, col_in;
   logic              mat_last, eri_last;
   logic [MAT_AW-1:0] mat_next;

   always_comb begin
      mat_last = mat_ff == MAT_AW'(MAT_N - 1);
      eri_last = eri_ff == ERI_AW'(ERI_N - 1);
      mat_next = mat_last ? '0 : mat_ff + MAT_AW'(1);

      state_in = state_ff;
      mat_in   = mat_ff;
      j_in     = j_ff;
      eri_in   = eri_ff;
      row_in   = row_ff;
      col_in   = col_ff;

      cmd            = '0;
      cmd.mode       = MODE_J;
      cmd.mat_addr   = mat_ff;
      cmd.eri_addr   = eri_ff;
      cmd.wr_idx     = mat_ff;
      cmd.grp_end    = mat_last;
      cmd.row        = row_ff;
      cmd.col        = col_ff;
      cmd.last       = mat_last;

      case (state_ff)
         S_IDLE: begin
            if (req_accept && req_data.kind == KIND_START) begin
               cmd.clear = 1'b1;
               mat_in    = '0;
               j_in      = '0;
               eri_in    = '0;
               row_in    = '0;
               col_in    = '0;
               state_in  = S_JACC;
            end
         end
         S_JACC: begin
            cmd.issue  = 1'b1;
            cmd.wr_idx = j_ff;
            mat_in     = mat_next;
            eri_in     = eri_last ? '0 : eri_ff + ERI_AW'(1);
            if (mat_last) begin
               j_in = j_ff + MAT_AW'(1);
            end
            if (eri_last) begin
               state_in = S_NACC;
            end
         end
         S_NACC: begin
            cmd.issue = 1'b1;
            cmd.mode  = MODE_N;
            mat_in    = mat_next;
            if (mat_last) begin
               state_in = S_WAITN;
            end
         end
         S_WAITN: begin
            if (st.n_done) begin
               state_in = S_XMUL;
            end
         end
         S_XMUL: begin
            cmd.x_load = 1'b1;
            state_in   = S_RXS;
         end
         S_RXS: begin
            cmd.root_start = 1'b1;
            state_in       = S_RXW;
         end
         S_RXW: begin
            if (!st.root_busy) begin
               state_in = S_RNS;
            end
         end
         S_RNS: begin
            // latch v from the first root while the unit restarts on n
            cmd.v_load     = 1'b1;
            cmd.root_start = 1'b1;
            cmd.root_sel_n = 1'b1;
            state_in       = S_RNW;
         end
         S_RNW: begin
            cmd.root_sel_n = 1'b1;
            if (!st.root_busy) begin
               state_in = S_MMUL;
            end
         end
         S_MMUL: begin
            cmd.m_load = 1'b1;
            state_in   = S_EMUL;
         end
         S_EMUL: begin
            cmd.e_load = 1'b1;
            state_in   = S_FACC;
         end
         S_FACC: begin
            cmd.issue = 1'b1;
            cmd.mode  = MODE_F;
            mat_in    = mat_next;
            if (mat_last) begin
               state_in = S_FWAIT;
            end
         end
         S_FWAIT: begin
            if (st.f_done) begin
               state_in = S_ERD;
            end
         end
         S_ERD: begin
            state_in = S_ELD;
         end
         S_ELD: begin
            cmd.out_load = 1'b1;
            state_in     = S_EWAIT;
         end
         S_EWAIT: begin
            if (!rsp_stall) begin
               mat_in = mat_next;
               if (col_ff == 3'(DIM - 1)) begin
                  col_in = '0;
                  row_in = row_ff + 3'd1;
               end else begin
                  col_in = col_ff + 3'd1;
               end
               state_in = mat_last ? S_IDLE : S_ERD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mat_ff   <= '0;
         j_ff     <= '0;
         eri_ff   <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mat_ff   <= mat_in;
         j_ff     <= j_in;
         eri_ff   <= eri_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_EWAIT;

endmodule

// ===== hdl/fock_matrix_builder.sv =====
// Load words: one per cycle while the controller is idle, no result.
// Compute word: streams the integral store through the single multiply-accumulate
// pipe, then the electron count, two runs of the cube-root unit and the Fock sum;
// then the results follow one at a time, and no new word is taken until the last.
// Reset clears the controller and flags; the stores stay undefined until written.
module fock_matrix_builder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fmb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fmb_pkg::rsp_type rsp_data
);
   import fmb_pkg::*;

   cmd_type    cmd;
   status_type st;
   logic       req_accept;

   assign req_accept = req_valid && !req_stall;

   fmb_ctrl u_ctrl (
      .clock, .reset, .req_accept, .req_data, .rsp_stall, .st, .cmd,
      .req_stall, .rsp_valid);

   fmb_datapath u_datapath (
      .clock, .reset, .req_accept, .req_data, .cmd, .st, .rsp_data);

endmodule

// ===== hdl/fmb_checker.sv =====
module fmb_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input fmb_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input fmb_pkg::rsp_type rsp_data
);
   import fmb_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   // no load is taken while a compute is still delivering
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while results pending");

   // drop valid and reopen the input after the final element is taken
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.last |=> !rsp_valid && !req_stall)
      else $error("result after last element");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.last ==
         (rsp_data.row == 3'(DIM - 1) && rsp_data.col == 3'(DIM - 1)))
      else $error("last flag on wrong element");

endmodule

bind fock_matrix_builder fmb_checker u_fmb_checker (.*);

// ===== tb/tb.sv =====
module tb;
   import fmb_pkg::*;

   typedef struct {
      req_type     w;
      bit          drain;
      int unsigned phase;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   pending_type pend_q[$];
   rsp_type     fock_q[$];

   logic signed [31:0] dens_mem[MAT_N];
   logic signed [31:0] ovl_mem[MAT_N];
   logic signed [31:0] kin_mem[MAT_N];
   logic signed [31:0] nuc_mem[MAT_N];
   logic signed [31:0] eri_mem[ERI_N];

   int unsigned send_idle = 0, recv_idle = 0;
   int unsigned words_in = 0, builds = 0, elems_checked = 0;
   int unsigned errors = 0, idle_cycles = 0;
   localparam int unsigned HANG_LIMIT = 20000;

   fock_matrix_builder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint fx_mul(logic signed [31:0] a, logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> FRAC_BITS;
   endfunction

   function automatic logic signed [31:0] clamp_word(longint v, inout bit flag);
      if (v > 64'sd2147483647) begin
         flag = 1'b1;
         return 32'sh7FFFFFFF;
      end
      if (v < -64'sd2147483648) begin
         flag = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // floor cube root of x scaled by 2^(2*FRAC_BITS)
   function automatic logic [63:0] cube_root(logic [31:0] x);
      logic [127:0] target, cube;
      logic [63:0]  y, c;
      target = 128'(x) << (2 * FRAC_BITS);
      y = '0;
      for (int b = 27; b >= 0; b--) begin
         c = y | (64'd1 << b);
         cube = 128'(c) * 128'(c) * 128'(c);
         if (cube <= target) y = c;
      end
      return y;
   endfunction

   task automatic build_fock();
      logic signed [31:0] jm[MAT_N];
      logic signed [31:0] n, v, energy;
      logic [63:0]        x, c, m, e;
      longint             acc;
      bit                 sat;
      rsp_type            r;
      sat = 1'b0;
      for (int mu = 0; mu < DIM; mu++)
         for (int nu = 0; nu < DIM; nu++) begin
            acc = 0;
            for (int la = 0; la < DIM; la++)
               for (int si = 0; si < DIM; si++)
                  acc += fx_mul(dens_mem[la * DIM + si],
                                eri_mem[((mu * DIM + nu) * DIM + la) * DIM + si]);
            jm[mu * DIM + nu] = clamp_word(acc, sat);
         end
      acc = 0;
      for (int k = 0; k < MAT_N; k++) acc += fx_mul(dens_mem[k], ovl_mem[k]);
      n = clamp_word(acc, sat);
      if (n < 1) n = 1;
      x = (64'(unsigned'(n)) * 64'(THREE_OVER_PI_Q32) + 64'h80000000) >> 32;
      v = -$signed(32'(cube_root(x[31:0])));
      c = cube_root(n);
      m = (64'(unsigned'(n)) * c + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      e = (m * 64'(CX_Q24) + (64'd1 << 23)) >> 24;
      if (e > 64'h80000000) begin
         sat = 1'b1;
         energy = 32'sh80000000;
      end else begin
         energy = 32'(-e);
      end
      for (int k = 0; k < MAT_N; k++)
         jm[k] = clamp_word(longint'(kin_mem[k]) + longint'(nuc_mem[k]) + longint'(jm[k])
                            + fx_mul(v, ovl_mem[k]), sat);
      for (int k = 0; k < MAT_N; k++) begin
         r.row        = 3'(k / DIM);
         r.col        = 3'(k % DIM);
         r.fock_value = jm[k];
         r.xc_energy  = energy;
         r.saturated  = sat;
         r.last       = (k == MAT_N - 1);
         fock_q.push_back(r);
      end
      builds++;
   endtask

   task automatic absorb_word(req_type w);
      case (w.kind)
         KIND_DENSITY:  if (w.address < MAT_N) dens_mem[w.address] = w.value;
         KIND_OVERLAP:  if (w.address < MAT_N) ovl_mem[w.address] = w.value;
         KIND_KINETIC:  if (w.address < MAT_N) kin_mem[w.address] = w.value;
         KIND_NUCLEAR:  if (w.address < MAT_N) nuc_mem[w.address] = w.value;
         KIND_INTEGRAL: if (w.address < ERI_N) eri_mem[w.address] = w.value;
         KIND_START:    build_fock();
         default: ;
      endcase
   endtask

   // driver: hold the word while stalled, then pick the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            absorb_word(req_data);
            words_in++;
         end
         if (pend_q.size() > 0 && !(pend_q[0].drain && fock_q.size() > 0)
             && $urandom_range(99) >= send_idle) begin
            req_valid <= 1'b1;
            req_data  <= pend_q[0].w;
            case (pend_q[0].phase)
               0: begin send_idle = 15; recv_idle = 82; end
               1: begin send_idle = 82; recv_idle = 15; end
               default: begin send_idle = 0; recv_idle = 0; end
            endcase
            void'(pend_q.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (fock_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected word: %p", rsp_data);
            end else begin
               if (rsp_data !== fock_q[0]) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected %p, got %p", fock_q[0], rsp_data);
               end
               void'(fock_q.pop_front());
               elems_checked++;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic signed [31:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 70) return $signed(32'($urandom_range(262143))) - 32'sd131072;
      if (sel < 90) return $urandom;
      return sel[0] ? 32'sh7FFFFFFF : 32'sh80000000;
   endfunction

   task automatic queue_word(logic [2:0] kind, logic [11:0] address,
                             logic signed [31:0] value, bit drain, int unsigned phase);
      pending_type p;
      p.w.kind    = kind;
      p.w.address = address;
      p.w.value   = value;
      p.drain     = drain;
      p.phase     = phase;
      pend_q.push_back(p);
   endtask

   initial begin
      int unsigned sel;
      logic [2:0]  kind;
      logic [11:0] address;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // fill every store; density zero so the first build clamps the count
      for (int k = 0; k < MAT_N; k++) begin
         queue_word(KIND_DENSITY, 12'(k), 32'sd0, 1'b0, 0);
         queue_word(KIND_OVERLAP, 12'(k), 32'sd65536 + $urandom_range(65535), 1'b0, 0);
         queue_word(KIND_KINETIC, 12'(k), pick_value(), 1'b0, 0);
         queue_word(KIND_NUCLEAR, 12'(k), pick_value(), 1'b0, 0);
      end
      for (int k = 0; k < ERI_N; k++)
         queue_word(KIND_INTEGRAL, 12'(k), $signed(32'($urandom_range(131071))) - 32'sd65536,
                    1'b0, 0);

      queue_word(KIND_START, 12'd0, 32'sd0, 1'b0, 0);
      queue_word(KIND_DENSITY, 12'd0, 32'sd65536, 1'b1, 0);
      queue_word(KIND_DENSITY, 12'd9, 32'sd131072, 1'b0, 0);
      queue_word(KIND_START, 12'd0, 32'sd0, 1'b0, 0);
      queue_word(KIND_DENSITY, 12'd63, 32'sh7FFFFFFF, 1'b1, 0);
      queue_word(KIND_OVERLAP, 12'd0, 32'sh80000000, 1'b0, 0);
      queue_word(KIND_INTEGRAL, 12'd4095, 32'sh7FFFFFFF, 1'b0, 0);
      queue_word(KIND_KINETIC, 12'd0, 32'sh7FFFFFFF, 1'b0, 0);
      queue_word(KIND_NUCLEAR, 12'd63, 32'sh80000000, 1'b0, 0);
      // out-of-range matrix addresses and unused kinds: dropped
      queue_word(KIND_DENSITY, 12'd64, 32'sh12345678, 1'b0, 0);
      queue_word(KIND_OVERLAP, 12'd4095, 32'shFFFFFFFF, 1'b0, 0);
      queue_word(3'd6, 12'hAAA, 32'sh55555555, 1'b0, 0);
      queue_word(3'd7, 12'h555, 32'shAAAAAAAA, 1'b0, 0);
      queue_word(KIND_START, 12'hFFF, 32'shFFFFFFFF, 1'b0, 0);
      queue_word(KIND_DENSITY, 12'd63, 32'sd32768, 1'b1, 0);
      queue_word(KIND_OVERLAP, 12'd0, 32'sd65536, 1'b0, 0);
      queue_word(KIND_INTEGRAL, 12'd4095, 32'sd1000, 1'b0, 0);
      queue_word(KIND_KINETIC, 12'd0, 32'sd0, 1'b0, 0);
      queue_word(KIND_NUCLEAR, 12'd63, -32'sd65536, 1'b0, 0);
      queue_word(KIND_START, 12'd0, 32'sd0, 1'b0, 0);

      for (int i = 0; i < 250; i++) begin
         sel = $urandom_range(99);
         if (sel < 4) kind = KIND_START;
         else if (sel < 7) kind = 3'($urandom_range(7, 6));
         else if (sel < 75) kind = 3'($urandom_range(3));
         else kind = KIND_INTEGRAL;
         address = (kind <= KIND_NUCLEAR && $urandom_range(99) < 85) ?
                   12'($urandom_range(MAT_N - 1)) : 12'($urandom);
         queue_word(kind, address, pick_value(), (i % 84) == 0, i / 84);
      end

      @(posedge clock);
      while (pend_q.size() > 0 || req_valid || fock_q.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("run: %0d words accepted, %0d Fock builds, %0d elements checked",
               words_in, builds, elems_checked);
      $display("covered load extremes, dropped addresses and kinds, clamp and saturation");
      if (errors == 0 && fock_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("mismatches: %0d", errors);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/fmb_pkg.sv
hdl/fmb_ram.sv
hdl/fmb_cbrt.sv
hdl/fmb_datapath.sv
hdl/fmb_ctrl.sv
hdl/fock_matrix_builder.sv
hdl/fmb_checker.sv
tb/tb.sv
